// File: rtl/core/mncr_pkg.sv
// ----------------------------------------------------------------------------
// mncr_pkg
// Shared types, constants and command codes for the cubic root refiner.
// ----------------------------------------------------------------------------
package mncr_pkg;

  localparam int WORD_BITS = 32;
  localparam int ACC_BITS  = 64;
  localparam int FRAC_BITS = 16;

  localparam logic [30:0] Q_ONE_HUNDRED = 31'd6553600;
  localparam logic [30:0] CHANGE_MAX    = 31'h7FFF_FFFF;

  localparam logic signed [31:0] RST_CUBIC    = 32'sd65536;
  localparam logic signed [31:0] RST_SQUARE   = -32'sd327680;
  localparam logic signed [31:0] RST_LINEAR   = 32'sd458752;
  localparam logic signed [31:0] RST_CONSTANT = -32'sd196608;
  localparam logic [30:0]        RST_TOL      = 31'd6554;
  localparam logic [7:0]         RST_LIMIT    = 8'd100;

  typedef enum logic [2:0] {
    REG_CUBIC    = 3'd0,
    REG_SQUARE   = 3'd1,
    REG_LINEAR   = 3'd2,
    REG_CONSTANT = 3'd3,
    REG_TOL      = 3'd4,
    REG_LIMIT    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DEN  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_DONE
  } ctrl_state_t;

  // datapath micro operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,    // x <- start value, change <- 100
    OP_MUL,     // p <- qmul(a_sel, b_sel) (multi cycle)
    OP_ADD,     // r[dst] <- sadd(p, b_sel)
    OP_SUB,     // r[dst] <- ssub(a_sel, b_sel)
    OP_DIV,     // quotient unit (multi cycle)
    OP_UPDATE,  // q <- signed quotient num/den
    OP_PCT,     // change division
    OP_COMMIT   // x <- clamp(x - q), diff
  } op_t;

  // register file slots
  typedef enum logic [3:0] {
    R_X, R_F, R_G, R_H, R_T, R_NUM, R_DEN, R_GG, R_FH, R_Q, R_DIFF,
    R_C3, R_C2, R_C1, R_C0, R_ZERO
  } slot_t;

  typedef struct packed {
    op_t   op;
    slot_t a;
    slot_t b;
    slot_t dst;
    logic  a_x3;  // multiply a by 3
    logic  a_x6;
    logic  b_x2;  // add operand doubled
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic den_zero;
    logic x1_zero;
    logic conv;
  } dp_stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_sub = s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // magnitude with sign to saturated signed value
  function automatic logic signed [63:0] from_mag(input logic neg,
                                                  input logic ovf,
                                                  input logic [63:0] m);
    if (neg) begin
      if (ovf || m[63]) from_mag = {1'b1, 63'd0};
      else from_mag = 64'(-m);
    end else begin
      if (ovf || m[63]) from_mag = {1'b0, {63{1'b1}}};
      else from_mag = m;
    end
  endfunction

  function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd0;
    hi[WORD_BITS-2:0] = '1;
    lo = ~hi;
    if (v > hi) clamp_word = hi;
    else if (v < lo) clamp_word = lo;
    else clamp_word = v;
  endfunction

endpackage

// File: rtl/core/mncr_if.sv
// ----------------------------------------------------------------------------
// mncr_in_if / mncr_out_if
// Valid/ready channels for start values and results.
// ----------------------------------------------------------------------------
interface mncr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_value;
  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface mncr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root;
  logic [7:0]         iterations_used;
  logic [30:0]        change_percent;
  logic [1:0]         status;
  modport source (output valid, output root, output iterations_used,
                  output change_percent, output status, input ready);
  modport sink   (input valid, input root, input iterations_used,
                  input change_percent, input status, output ready);
endinterface

// File: rtl/core/mncr_mul.sv
// ----------------------------------------------------------------------------
// mncr_mul
// Signed Q16.16 multiply of 64-bit operands, four 32x32 partial products,
// one per cycle, result saturated to 64 bits.
// ----------------------------------------------------------------------------
module mncr_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               busy,
  output logic signed [63:0] p
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [127:0] acc;
  logic [2:0]   step;
  logic         run;
  logic [63:0]  pp;
  logic [31:0]  opa;
  logic [31:0]  opb;

  always_comb begin
    case (step[1:0])
      2'd0:    begin opa = ma[31:0];  opb = mb[31:0];  end
      2'd1:    begin opa = ma[31:0];  opb = mb[63:32]; end
      2'd2:    begin opa = ma[63:32]; opb = mb[31:0];  end
      default: begin opa = ma[63:32]; opb = mb[63:32]; end
    endcase
    pp = 64'(opa) * 64'(opb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
    end else if (start) begin
      run  <= 1'b1;
      step <= '0;
    end else if (run) begin
      step <= step + 3'd1;
      if (step == 3'd3) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= mncr_pkg::mag(a);
      mb  <= mncr_pkg::mag(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (run) begin
      case (step[1:0])
        2'd0:    acc <= acc + 128'(pp);
        2'd1:    acc <= acc + (128'(pp) << 32);
        2'd2:    acc <= acc + (128'(pp) << 32);
        default: acc <= acc + (128'(pp) << 64);
      endcase
    end
  end

  assign busy = run | start;
  assign p = mncr_pkg::from_mag(neg, |acc[127:80], acc[79:16]);

endmodule

// File: rtl/core/mncr_div.sv
// ----------------------------------------------------------------------------
// mncr_div
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit a
// cycle, quotient saturated to all ones when it does not fit 64 bits.
// ----------------------------------------------------------------------------
module mncr_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] dividend,
  input  logic [63:0]  divisor,
  output logic         busy,
  output logic [63:0]  quotient
);

  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] d;
  logic [63:0] q;
  logic [6:0]  cnt;
  logic        run;
  logic        sat;
  logic [64:0] shifted;
  logic        take;

  assign shifted = {rem, lo[63]};
  assign take = shifted >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= dividend[127:64] < divisor;
      cnt <= 7'd64;
    end else if (run) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[127:64];
      lo  <= dividend[63:0];
      d   <= divisor;
      q   <= '0;
      sat <= dividend[127:64] >= divisor;
    end else if (run) begin
      lo  <= lo << 1;
      q   <= {q[62:0], take};
      rem <= take ? 64'(shifted - {1'b0, d}) : shifted[63:0];
    end
  end

  assign busy = run | start;
  assign quotient = sat ? '1 : q;

endmodule

// File: rtl/core/mncr_datapath.sv
// ----------------------------------------------------------------------------
// mncr_datapath
// Register file, shared multiplier and divider, adders and the percent
// change logic, driven one micro operation at a time by the controller.
// ----------------------------------------------------------------------------
module mncr_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  mncr_pkg::dp_cmd_t        cmd,
  input  logic signed [31:0]       start_value,
  input  logic signed [31:0]       coef_cubic,
  input  logic signed [31:0]       coef_square,
  input  logic signed [31:0]       coef_linear,
  input  logic signed [31:0]       coef_constant,
  input  logic [30:0]              tolerance_percent,
  output mncr_pkg::dp_stat_t       stat,
  output logic signed [31:0]       root,
  output logic [30:0]              change_percent
);

  logic signed [63:0] rf [0:10];
  logic signed [63:0] va;
  logic signed [63:0] vb;
  logic signed [63:0] ma_op;
  logic signed [63:0] ab_op;
  logic signed [63:0] p;
  logic               mul_busy;
  logic               div_busy;
  logic               div_start;
  logic [127:0]       dividend;
  logic [63:0]        divisor;
  logic [63:0]        quo;
  logic               pct_mode;
  logic [30:0]        change;
  logic signed [63:0] x1;
  logic [63:0]        mq;
  logic [63:0]        mdiff;
  logic [127:0]       hund;

  function automatic logic signed [63:0] rd(input mncr_pkg::slot_t s,
                                           input logic signed [63:0] r [0:10],
                                           input logic signed [31:0] c3,
                                           input logic signed [31:0] c2,
                                           input logic signed [31:0] c1,
                                           input logic signed [31:0] c0);
    case (s)
      mncr_pkg::R_C3:   rd = 64'(c3);
      mncr_pkg::R_C2:   rd = 64'(c2);
      mncr_pkg::R_C1:   rd = 64'(c1);
      mncr_pkg::R_C0:   rd = 64'(c0);
      mncr_pkg::R_ZERO: rd = '0;
      default:          rd = r[4'(s)];
    endcase
  endfunction

  assign va = rd(cmd.a, rf, coef_cubic, coef_square, coef_linear, coef_constant);
  assign vb = rd(cmd.b, rf, coef_cubic, coef_square, coef_linear, coef_constant);

  // coefficients are 32-bit so scaled copies fit 64 bits
  always_comb begin
    if (cmd.a_x3) ma_op = va + va + va;
    else if (cmd.a_x6) ma_op = (va + va + va) <<< 1;
    else ma_op = va;
    ab_op = cmd.b_x2 ? vb <<< 1 : vb;
  end

  mncr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == mncr_pkg::OP_MUL),
    .a     (ma_op),
    .b     (vb),
    .busy  (mul_busy),
    .p     (p)
  );

  assign mdiff = mncr_pkg::mag(rf[mncr_pkg::R_DIFF]);
  assign hund  = 128'(mdiff) * 128'd100;
  assign mq    = mncr_pkg::mag(rf[mncr_pkg::R_NUM]);

  always_comb begin
    if (cmd.op == mncr_pkg::OP_PCT) begin
      dividend = hund << 16;
      divisor  = mncr_pkg::mag(rf[mncr_pkg::R_X]);
    end else begin
      dividend = {48'd0, mq, 16'd0};
      divisor  = mncr_pkg::mag(rf[mncr_pkg::R_DEN]);
    end
  end
  assign div_start = (cmd.op == mncr_pkg::OP_DIV) || (cmd.op == mncr_pkg::OP_PCT);

  mncr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign x1 = mncr_pkg::clamp_word(mncr_pkg::sat_sub(rf[mncr_pkg::R_X],
                                                     rf[mncr_pkg::R_Q]));

  // percent write back only between the change division and the next request
  // or multiply
  always_ff @(posedge clk) begin
    if (rst) pct_mode <= 1'b0;
    else if (cmd.op == mncr_pkg::OP_PCT) pct_mode <= 1'b1;
    else if (cmd.op == mncr_pkg::OP_DIV || cmd.op == mncr_pkg::OP_MUL ||
             cmd.op == mncr_pkg::OP_LOAD) pct_mode <= 1'b0;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mncr_pkg::OP_LOAD: begin
        rf[mncr_pkg::R_X] <= mncr_pkg::clamp_word(64'(start_value));
        change <= mncr_pkg::Q_ONE_HUNDRED;
      end
      mncr_pkg::OP_ADD: rf[4'(cmd.dst)] <= mncr_pkg::sat_add(p, ab_op);
      mncr_pkg::OP_SUB: rf[4'(cmd.dst)] <= mncr_pkg::sat_sub(va, vb);
      mncr_pkg::OP_UPDATE: begin
        // quotient of num/den with sign; the new estimate is written at commit
        rf[mncr_pkg::R_Q] <= mncr_pkg::from_mag(
            rf[mncr_pkg::R_NUM][63] ^ rf[mncr_pkg::R_DEN][63], 1'b0, quo);
      end
      mncr_pkg::OP_COMMIT: begin
        rf[mncr_pkg::R_DIFF] <= mncr_pkg::sat_sub(x1, rf[mncr_pkg::R_X]);
        rf[mncr_pkg::R_X]    <= x1;
      end
      default: begin
        if (cmd.op == mncr_pkg::OP_NONE && cmd.dst != mncr_pkg::R_ZERO &&
            !mul_busy && !pct_mode)
          rf[4'(cmd.dst)] <= p;
        if (cmd.op == mncr_pkg::OP_NONE && cmd.dst == mncr_pkg::R_ZERO && pct_mode &&
            !div_busy)
          change <= (rf[mncr_pkg::R_X] == 64'sd0) ? mncr_pkg::CHANGE_MAX :
                    (|quo[63:31]) ? mncr_pkg::CHANGE_MAX : quo[30:0];
      end
    endcase
  end

  assign stat.busy     = mul_busy | div_busy;
  assign stat.den_zero = rf[mncr_pkg::R_DEN] == 64'sd0;
  assign stat.x1_zero  = rf[mncr_pkg::R_X] == 64'sd0;
  assign stat.conv     = change <= tolerance_percent;
  assign change_percent = change;
  assign root = 32'(mncr_pkg::clamp_word(rf[mncr_pkg::R_X]));

endmodule

// File: rtl/core/mncr_ctrl.sv
// ----------------------------------------------------------------------------
// mncr_ctrl
// Sequencer: walks the micro program of one refinement iteration, counts
// iterations and decides the exit status.
// ----------------------------------------------------------------------------
module mncr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic [7:0]          iteration_limit,
  input  mncr_pkg::dp_stat_t  stat,
  output mncr_pkg::dp_cmd_t   cmd,
  output logic [7:0]          iterations_used,
  output logic [1:0]          status
);

  mncr_pkg::ctrl_state_t state;
  mncr_pkg::ctrl_state_t state_next;
  logic [4:0]  pc;
  logic [7:0]  done_cnt;
  logic [1:0]  st;
  logic        first;
  mncr_pkg::dp_cmd_t pcmd;
  logic        waits;

  // micro program of one iteration; mul/div ops are followed by a wait, which
  // writes a mul or percent result on completion (the step quotient at update)
  always_comb begin
    pcmd = '{op: mncr_pkg::OP_NONE, a: mncr_pkg::R_ZERO, b: mncr_pkg::R_ZERO,
             dst: mncr_pkg::R_ZERO, a_x3: 1'b0, a_x6: 1'b0, b_x2: 1'b0};
    waits = 1'b0;
    case (pc)
      // f = ((c3*x + c2)*x + c1)*x + c0
      5'd0: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_C3;
        pcmd.b = mncr_pkg::R_X; waits = 1'b1; end
      5'd1: begin pcmd.op = mncr_pkg::OP_ADD; pcmd.b = mncr_pkg::R_C2;
        pcmd.dst = mncr_pkg::R_T; end
      5'd2: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_T;
        pcmd.b = mncr_pkg::R_X; waits = 1'b1; end
      5'd3: begin pcmd.op = mncr_pkg::OP_ADD; pcmd.b = mncr_pkg::R_C1;
        pcmd.dst = mncr_pkg::R_T; end
      5'd4: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_T;
        pcmd.b = mncr_pkg::R_X; waits = 1'b1; end
      5'd5: begin pcmd.op = mncr_pkg::OP_ADD; pcmd.b = mncr_pkg::R_C0;
        pcmd.dst = mncr_pkg::R_F; end
      // g = (3c3*x + 2c2)*x + c1
      5'd6: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_C3;
        pcmd.a_x3 = 1'b1; pcmd.b = mncr_pkg::R_X; waits = 1'b1; end
      5'd7: begin pcmd.op = mncr_pkg::OP_ADD; pcmd.b = mncr_pkg::R_C2;
        pcmd.b_x2 = 1'b1; pcmd.dst = mncr_pkg::R_T; end
      5'd8: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_T;
        pcmd.b = mncr_pkg::R_X; waits = 1'b1; end
      5'd9: begin pcmd.op = mncr_pkg::OP_ADD; pcmd.b = mncr_pkg::R_C1;
        pcmd.dst = mncr_pkg::R_G; end
      // h = 6c3*x + 2c2
      5'd10: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_C3;
        pcmd.a_x6 = 1'b1; pcmd.b = mncr_pkg::R_X; waits = 1'b1; end
      5'd11: begin pcmd.op = mncr_pkg::OP_ADD; pcmd.b = mncr_pkg::R_C2;
        pcmd.b_x2 = 1'b1; pcmd.dst = mncr_pkg::R_H; end
      5'd12: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_F;
        pcmd.b = mncr_pkg::R_G; pcmd.dst = mncr_pkg::R_NUM; waits = 1'b1; end
      5'd13: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_G;
        pcmd.b = mncr_pkg::R_G; pcmd.dst = mncr_pkg::R_GG; waits = 1'b1; end
      5'd14: begin pcmd.op = mncr_pkg::OP_MUL; pcmd.a = mncr_pkg::R_F;
        pcmd.b = mncr_pkg::R_H; pcmd.dst = mncr_pkg::R_FH; waits = 1'b1; end
      5'd15: begin pcmd.op = mncr_pkg::OP_SUB; pcmd.a = mncr_pkg::R_GG;
        pcmd.b = mncr_pkg::R_FH; pcmd.dst = mncr_pkg::R_DEN; end
      // 16: zero denominator check happens in S_CHECK
      5'd17: begin pcmd.op = mncr_pkg::OP_DIV; waits = 1'b1; end
      5'd18: begin pcmd.op = mncr_pkg::OP_UPDATE; end
      5'd19: begin pcmd.op = mncr_pkg::OP_COMMIT; end
      5'd20: begin pcmd.op = mncr_pkg::OP_PCT; waits = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mncr_pkg::S_IDLE;
      pc       <= '0;
      done_cnt <= '0;
      st       <= mncr_pkg::ST_LIMIT;
      first    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        mncr_pkg::S_IDLE: if (in_valid) begin
          pc <= '0; done_cnt <= '0; first <= 1'b1;
        end
        // check points keep pc so S_CHECK sees where it came from
        mncr_pkg::S_ISSUE: if (!waits && pc != 5'd16 && pc != 5'd21) pc <= pc + 5'd1;
        mncr_pkg::S_WAIT:  if (!stat.busy) pc <= pc + 5'd1;
        mncr_pkg::S_CHECK: begin
          first <= 1'b0;
          if (first && stat.conv) st <= mncr_pkg::ST_CONVERGED;
          else if (pc == 5'd16) begin
            if (stat.den_zero) st <= mncr_pkg::ST_ZERO_DEN;
            else pc <= 5'd17;
          end else begin
            if (!first) done_cnt <= done_cnt + 8'd1;
            pc <= '0;
            if (!first && !stat.x1_zero && stat.conv) st <= mncr_pkg::ST_CONVERGED;
            else st <= mncr_pkg::ST_LIMIT;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{op: mncr_pkg::OP_NONE, a: mncr_pkg::R_ZERO, b: mncr_pkg::R_ZERO,
            dst: mncr_pkg::R_ZERO, a_x3: 1'b0, a_x6: 1'b0, b_x2: 1'b0};
    case (state)
      mncr_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op = mncr_pkg::OP_LOAD;
          state_next = mncr_pkg::S_CHECK;
        end
      end
      mncr_pkg::S_ISSUE: begin
        cmd = pcmd;
        if (pc == 5'd16 || pc == 5'd21) state_next = mncr_pkg::S_CHECK;
        else if (waits) state_next = mncr_pkg::S_WAIT;
      end
      mncr_pkg::S_WAIT: begin
        // completion cycle doubles as the write back of the unit result
        cmd.dst = pcmd.dst;
        if (pcmd.op == mncr_pkg::OP_MUL && pcmd.dst == mncr_pkg::R_ZERO)
          cmd.dst = mncr_pkg::R_Q;
        if (!stat.busy) state_next = mncr_pkg::S_ISSUE;
      end
      mncr_pkg::S_CHECK: begin
        if (first) begin
          if (stat.conv || iteration_limit == 8'd0) state_next = mncr_pkg::S_DONE;
          else state_next = mncr_pkg::S_ISSUE;
        end else if (pc == 5'd16) begin
          state_next = stat.den_zero ? mncr_pkg::S_DONE : mncr_pkg::S_ISSUE;
        end else if (!stat.x1_zero && stat.conv) state_next = mncr_pkg::S_DONE;
        else if (done_cnt + 8'd1 >= iteration_limit) state_next = mncr_pkg::S_DONE;
        else state_next = mncr_pkg::S_ISSUE;
      end
      mncr_pkg::S_DONE: if (out_ready) state_next = mncr_pkg::S_IDLE;
      default: state_next = mncr_pkg::S_IDLE;
    endcase
  end

  assign in_ready        = state == mncr_pkg::S_IDLE;
  assign out_valid       = state == mncr_pkg::S_DONE;
  assign iterations_used = done_cnt;
  assign status          = st;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(iterations_used))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output overlap");
  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> iterations_used <= iteration_limit)
    else $error("iteration count over limit");
`endif

endmodule

// File: rtl/core/modified_newton_cubic_root.sv
// ----------------------------------------------------------------------------
// modified_newton_cubic_root
// Modified Newton-Raphson refinement of a cubic root in signed Q16.16.
// ----------------------------------------------------------------------------
// A request on req carries one start value. The block runs up to
// iteration_limit refinement steps x - f*g/(g*g - f*h) and returns one
// result on rsp: root, iterations used, last percent change and status.
// Each iteration runs 9 multiplies on the shared partial product multiplier
// and two divisions (step and percent change); a division that saturates
// ends early. One request is in flight at a time: req.ready is high only
// when idle. The result stays on rsp until taken; the block waits while
// rsp.ready is low. Reset (rst, synchronous) returns to idle and
// restores register defaults. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module modified_newton_cubic_root (
  input  logic        clk,
  input  logic        rst,
  mncr_in_if.sink     req,
  mncr_out_if.source  rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] coef_cubic;
  logic signed [31:0] coef_square;
  logic signed [31:0] coef_linear;
  logic signed [31:0] coef_constant;
  logic [30:0]        tolerance_percent;
  logic [7:0]         iteration_limit;
  mncr_pkg::dp_cmd_t  cmd;
  mncr_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cubic        <= mncr_pkg::RST_CUBIC;
      coef_square       <= mncr_pkg::RST_SQUARE;
      coef_linear       <= mncr_pkg::RST_LINEAR;
      coef_constant     <= mncr_pkg::RST_CONSTANT;
      tolerance_percent <= mncr_pkg::RST_TOL;
      iteration_limit   <= mncr_pkg::RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mncr_pkg::REG_CUBIC:    coef_cubic        <= cfg_data;
        mncr_pkg::REG_SQUARE:   coef_square       <= cfg_data;
        mncr_pkg::REG_LINEAR:   coef_linear       <= cfg_data;
        mncr_pkg::REG_CONSTANT: coef_constant     <= cfg_data;
        mncr_pkg::REG_TOL:      tolerance_percent <= cfg_data[30:0];
        mncr_pkg::REG_LIMIT:    iteration_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mncr_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .iteration_limit (iteration_limit),
    .stat            (stat),
    .cmd             (cmd),
    .iterations_used (rsp.iterations_used),
    .status          (rsp.status)
  );

  mncr_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .start_value       (req.start_value),
    .coef_cubic        (coef_cubic),
    .coef_square       (coef_square),
    .coef_linear       (coef_linear),
    .coef_constant     (coef_constant),
    .tolerance_percent (tolerance_percent),
    .stat              (stat),
    .root              (rsp.root),
    .change_percent    (rsp.change_percent)
  );

endmodule

// File: tb/tb_modified_newton_cubic_root.sv
// ----------------------------------------------------------------------------
// tb_modified_newton_cubic_root
// Self-checking bench for the cubic root refiner: directed rows from a
// table, then random coefficient sets and start values, each result checked
// against a fixed-point modified Newton model or a result given in the row.
// ----------------------------------------------------------------------------
module tb_modified_newton_cubic_root;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic signed [31:0] root;
    logic [7:0]         iters;
    logic [30:0]        change;
    mncr_pkg::status_t  status;
  } root_result_t;

  typedef struct {
    bit                 is_cfg;
    mncr_pkg::reg_idx_t idx;
    logic [31:0]        data;
    bit                 typed;
    root_result_t       res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        req_taken, rsp_taken;
  int          errors = 0;
  int          idle_cycles = 0;

  mncr_in_if  req_ch();
  mncr_out_if rsp_ch();

  modified_newton_cubic_root dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // register mirror
  logic signed [63:0] m_cubic, m_square, m_linear, m_const;
  logic [30:0]        m_tol;
  logic [7:0]         m_limit;

  root_result_t pending_roots[$];
  stim_row_t    rows[$];

  function automatic logic signed [63:0] from_magnitude(bit neg, logic [127:0] m);
    if (m >= 128'h8000_0000_0000_0000) return neg ? 64'sh8000_0000_0000_0000
                                                  : 64'sh7FFF_FFFF_FFFF_FFFF;
    return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic [127:0] p;
    p = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> 16;
    return from_magnitude((a < 0) != (b < 0), p);
  endfunction

  function automatic logic signed [63:0] fx_div(logic signed [63:0] n,
                                                logic signed [63:0] d);
    logic [127:0] num, q;
    num = {64'd0, abs64(n)} << 16;
    if ((num >> 64) >= {64'd0, abs64(d)}) q = {64'd0, {64{1'b1}}};
    else q = num / {64'd0, abs64(d)};
    return from_magnitude((n < 0) != (d < 0), q);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000
                                     : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000
                                     : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic root_result_t refine_root(logic [31:0] start);
    root_result_t r;
    logic signed [63:0] x, f, g, h, num, den, x1, diff;
    logic [127:0] pct;
    logic [63:0] change;
    int done;
    bit converged;
    x = $signed(start);
    change = 64'(mncr_pkg::Q_ONE_HUNDRED);
    done = 0;
    converged = change <= m_tol;
    r.status = converged ? mncr_pkg::ST_CONVERGED : mncr_pkg::ST_LIMIT;
    while (!converged && done < m_limit) begin
      f = add_sat(fx_mul(add_sat(fx_mul(add_sat(fx_mul(m_cubic, x), m_square), x),
                                 m_linear), x), m_const);
      g = add_sat(fx_mul(add_sat(fx_mul(3 * m_cubic, x), 2 * m_square), x), m_linear);
      h = add_sat(fx_mul(6 * m_cubic, x), 2 * m_square);
      num = fx_mul(f, g);
      den = sub_sat(fx_mul(g, g), fx_mul(f, h));
      if (den == 0) begin
        r.status = mncr_pkg::ST_ZERO_DEN;
        break;
      end
      x1 = clamp32(sub_sat(x, fx_div(num, den)));
      diff = sub_sat(x1, x);
      if (x1 == 0) begin
        change = 64'(mncr_pkg::CHANGE_MAX);
      end else begin
        pct = (({64'd0, abs64(diff)} * 128'd100) << 16) / {64'd0, abs64(x1)};
        change = pct > 128'(mncr_pkg::CHANGE_MAX) ? 64'(mncr_pkg::CHANGE_MAX)
                                                  : pct[63:0];
      end
      x = x1;
      done++;
      if (x1 != 0 && change <= m_tol) begin
        r.status = mncr_pkg::ST_CONVERGED;
        converged = 1'b1;
      end
    end
    r.root = x[31:0];
    r.iters = done[7:0];
    r.change = change[30:0];
    return r;
  endfunction

  function automatic void add_cfg(mncr_pkg::reg_idx_t idx, logic [31:0] data);
    stim_row_t s;
    s.is_cfg = 1'b1; s.idx = idx; s.data = data; s.typed = 1'b0; s.res = '0;
    rows.push_back(s);
  endfunction

  function automatic void add_start(logic [31:0] v);
    stim_row_t s;
    s.is_cfg = 1'b0; s.idx = mncr_pkg::REG_CUBIC; s.data = v; s.typed = 1'b0;
    s.res = '0;
    rows.push_back(s);
  endfunction

  // start value with a result that can be read off directly
  function automatic void add_known(logic [31:0] v, logic [7:0] it,
                                    logic [30:0] ch, mncr_pkg::status_t st);
    stim_row_t s;
    s.is_cfg = 1'b0; s.idx = mncr_pkg::REG_CUBIC; s.data = v; s.typed = 1'b1;
    s.res.root = v; s.res.iters = it; s.res.change = ch; s.res.status = st;
    rows.push_back(s);
  endfunction

  // called at a falling edge
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(mncr_pkg::reg_idx_t idx, logic [31:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mncr_pkg::REG_CUBIC:    m_cubic = $signed(data);
      mncr_pkg::REG_SQUARE:   m_square = $signed(data);
      mncr_pkg::REG_LINEAR:   m_linear = $signed(data);
      mncr_pkg::REG_CONSTANT: m_const = $signed(data);
      mncr_pkg::REG_TOL:      m_tol = data[30:0];
      mncr_pkg::REG_LIMIT:    m_limit = data[7:0];
      default: ;
    endcase
  endtask

  // valid may stay high into the next request; the block is not ready then
  task automatic send_start(logic [31:0] v, bit typed, root_result_t known);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.start_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    pending_roots.push_back(typed ? known : refine_root(v));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 1048576)) - 524288);
  endfunction

  // stimulus
  initial begin
    root_result_t none;
    none = '0;
    req_ch.valid = 1'b0;
    req_ch.start_value = '0;
    m_cubic = mncr_pkg::RST_CUBIC; m_square = mncr_pkg::RST_SQUARE;
    m_linear = mncr_pkg::RST_LINEAR; m_const = mncr_pkg::RST_CONSTANT;
    m_tol = mncr_pkg::RST_TOL; m_limit = mncr_pkg::RST_LIMIT;

    // default polynomial has a double root at 1.0
    add_start(32'h0000_0000);
    add_start(32'h7FFF_FFFF);
    add_start(32'h8000_0000);
    add_start(32'h0004_0000);
    add_known(32'h0001_0000, 8'd0, mncr_pkg::Q_ONE_HUNDRED, mncr_pkg::ST_ZERO_DEN);
    add_cfg(mncr_pkg::REG_LIMIT, 32'd0);
    add_known(32'h0002_0000, 8'd0, mncr_pkg::Q_ONE_HUNDRED, mncr_pkg::ST_LIMIT);
    add_cfg(mncr_pkg::REG_LIMIT, 32'd1);
    add_cfg(mncr_pkg::REG_TOL, 32'd0);
    add_start(32'h0000_8000);
    add_cfg(mncr_pkg::REG_TOL, 32'h7FFF_FFFF);
    add_known(32'hFFFF_0000, 8'd0, mncr_pkg::Q_ONE_HUNDRED, mncr_pkg::ST_CONVERGED);
    add_cfg(mncr_pkg::REG_TOL, 32'(mncr_pkg::Q_ONE_HUNDRED));
    add_known(32'h1234_5678, 8'd0, mncr_pkg::Q_ONE_HUNDRED, mncr_pkg::ST_CONVERGED);
    add_cfg(mncr_pkg::REG_TOL, 32'd6554);
    add_cfg(mncr_pkg::REG_LIMIT, 32'd255);
    add_start(32'h0005_0000);
    add_cfg(mncr_pkg::REG_CUBIC, 32'h7FFF_FFFF);
    add_cfg(mncr_pkg::REG_SQUARE, 32'h8000_0000);
    add_cfg(mncr_pkg::REG_LINEAR, 32'h7FFF_FFFF);
    add_cfg(mncr_pkg::REG_CONSTANT, 32'h8000_0000);
    add_cfg(mncr_pkg::REG_LIMIT, 32'd8);
    add_start(32'hFFFF_0000);
    add_start(32'h1234_5678);
    add_start(32'hEDCB_A987);
    add_cfg(mncr_pkg::REG_CUBIC, 32'd0);
    add_cfg(mncr_pkg::REG_SQUARE, 32'd0);
    add_cfg(mncr_pkg::REG_LINEAR, 32'd0);
    add_cfg(mncr_pkg::REG_CONSTANT, 32'd0);
    add_known(32'h0003_0000, 8'd0, mncr_pkg::Q_ONE_HUNDRED, mncr_pkg::ST_ZERO_DEN);
    add_cfg(mncr_pkg::REG_CONSTANT, 32'h0001_0000);
    add_known(32'hFFFD_8000, 8'd0, mncr_pkg::Q_ONE_HUNDRED, mncr_pkg::ST_ZERO_DEN);
    // p(x) = x jumps straight to zero, which never counts as converged
    add_cfg(mncr_pkg::REG_CONSTANT, 32'd0);
    add_cfg(mncr_pkg::REG_LINEAR, 32'h0001_0000);
    add_cfg(mncr_pkg::REG_LIMIT, 32'd3);
    add_start(32'h0007_0000);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
      else send_start(rows[i].data, rows[i].typed, rows[i].res);
    end

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(mncr_pkg::REG_CUBIC, rand_coef());
      write_reg(mncr_pkg::REG_SQUARE, rand_coef());
      write_reg(mncr_pkg::REG_LINEAR, rand_coef());
      write_reg(mncr_pkg::REG_CONSTANT, rand_coef());
      write_reg(mncr_pkg::REG_TOL, ($urandom_range(0, 5) == 0) ? $urandom
                                                      : $urandom_range(0, 655360));
      write_reg(mncr_pkg::REG_LIMIT, (phase == 3) ? 32'd40 : $urandom_range(1, 12));
      for (int k = 0; k < 25; k++) begin
        // hold off until the block has drained
        if (k == 12) wait_idle();
        send_start(($urandom_range(0, 4) == 0) ? $urandom
                   : 32'($signed($urandom_range(0, 2097152)) - 1048576), 1'b0, none);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("modified_newton_cubic_root test passed");
    else $display("modified_newton_cubic_root test failed");
    $finish;
  end

  // result side with random stalls
  initial begin
    int stall;
    root_result_t want;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      if (pending_roots.size() == 0) begin
        $error("result with no request pending: root %h", rsp_ch.root);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        if (rsp_ch.root !== want.root) begin
          $error("root: expected %h got %h", want.root, rsp_ch.root); errors++;
        end
        if (rsp_ch.iterations_used !== want.iters) begin
          $error("iterations_used: expected %0d got %0d", want.iters,
                 rsp_ch.iterations_used); errors++;
        end
        if (rsp_ch.change_percent !== want.change) begin
          $error("change_percent: expected %h got %h", want.change,
                 rsp_ch.change_percent); errors++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, rsp_ch.status);
          errors++;
        end
      end
    end
  end

  assign req_taken = req_ch.valid && req_ch.ready;
  assign rsp_taken = rsp_ch.valid && rsp_ch.ready;

  always @(posedge clk) begin
    if (rst || req_taken || rsp_taken) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("modified_newton_cubic_root test failed");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/core/mncr_pkg.sv
rtl/core/mncr_if.sv
rtl/core/mncr_mul.sv
rtl/core/mncr_div.sv
rtl/core/mncr_datapath.sv
rtl/core/mncr_ctrl.sv
rtl/core/modified_newton_cubic_root.sv
tb/tb_modified_newton_cubic_root.sv
